/* hw/rtl/swti_pkg.sv */
// ----------------------------------------------------------------------------
// swti_pkg
// types, codes and character helpers shared by the sorted word table blocks
// ----------------------------------------------------------------------------
package swti_pkg;

    localparam int LEN_W = 6;

    localparam logic [7:0] CH_LOW_A = 8'h61;
    localparam logic [7:0] CH_LOW_Z = 8'h7a;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5a;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_EMPTY  = 2'd2;
    localparam logic [1:0] ST_BADIDX = 2'd3;

    typedef enum logic [2:0] {
        K_INS    = 3'd0,
        K_READ   = 3'd1,
        K_EMPTY  = 3'd2,
        K_FULL   = 3'd3,
        K_BADIDX = 3'd4
    } t_kind;

    typedef struct packed {
        logic       mode;
        logic [7:0] char_code;
        logic       word_end;
        logic [7:0] read_index;
    } t_in;

    typedef struct packed {
        logic [7:0] letter_out;
        logic       last_of_run;
        logic [7:0] insert_position;
        logic [1:0] status;
    } t_out;

    typedef struct packed {
        t_kind            kind;
        logic [LEN_W-1:0] key_len;
        logic [7:0]       read_index;
    } t_cmd;

    function automatic logic f_is_lower(input logic [7:0] c);
        return (c >= CH_LOW_A) && (c <= CH_LOW_Z);
    endfunction

    function automatic logic f_is_letter(input logic [7:0] c);
        return ((c >= CH_LOW_A) && (c <= CH_LOW_Z)) || ((c >= CH_UP_A) && (c <= CH_UP_Z));
    endfunction

endpackage

/* hw/rtl/sorted_word_table_insert.sv */
// a character transfer with no word end gives no result
// insert: the probes of a binary search, each comparing characters, then a move of each
//   entry after the position, through the order table's single read port
// read out: the last result follows a read of every stored character; empty word,
//   table full and invalid index results go straight to the output stage
// one command is worked at a time; a two entry queue lets input run ahead
// reset clears control state; no memory clearing pass
// ----------------------------------------------------------------------------
// sorted_word_table_insert
// keeps words sorted as they arrive: collects characters, places each word at
// its upper bound position by key, and reads stored words back as letters
// ----------------------------------------------------------------------------
module sorted_word_table_insert
    import swti_pkg::*;
#(
    parameter int TABLE_DEPTH = 256,
    parameter int MAX_CHARS   = 48
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    localparam int OAW = $clog2(TABLE_DEPTH);
    localparam int CAW = $clog2(TABLE_DEPTH * MAX_CHARS);

    // front to queue
    logic q_ready, push;
    t_cmd push_cmd;
    // queue to back
    logic q_valid, pop;
    t_cmd q_cmd;

    // character store, written by front at the next free slot, read by back
    logic                 char_we;
    logic [CAW-1:0]       char_waddr;
    logic [7:0]           char_wdata;
    logic                 cha_re, chb_re;
    logic [CAW-1:0]       cha_raddr, chb_raddr;
    logic [7:0]           cha_rdata, chb_rdata;

    // per slot {key length, stored length}
    logic                 len_we, len_re;
    logic [OAW-1:0]       len_waddr, len_raddr;
    logic [2*LEN_W-1:0]   len_wdata, len_rdata;

    swti_front #(.TABLE_DEPTH(TABLE_DEPTH), .MAX_CHARS(MAX_CHARS)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_data    (i_in_data),
        .i_q_ready    (q_ready),
        .o_cmd_valid  (push),
        .o_cmd        (push_cmd),
        .o_char_we    (char_we),
        .o_char_waddr (char_waddr),
        .o_char_wdata (char_wdata),
        .o_len_we     (len_we),
        .o_len_waddr  (len_waddr),
        .o_len_wdata  (len_wdata)
    );

    swti_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_cmd   (q_cmd),
        .i_pop   (pop)
    );

    // two copies of the character store so the search reads both words at once
    swti_ram #(.WIDTH(8), .DEPTH(TABLE_DEPTH * MAX_CHARS)) u_chars_a (
        .i_clk   (i_clk),
        .i_we    (char_we),
        .i_waddr (char_waddr),
        .i_wdata (char_wdata),
        .i_re    (cha_re),
        .i_raddr (cha_raddr),
        .o_rdata (cha_rdata)
    );

    swti_ram #(.WIDTH(8), .DEPTH(TABLE_DEPTH * MAX_CHARS)) u_chars_b (
        .i_clk   (i_clk),
        .i_we    (char_we),
        .i_waddr (char_waddr),
        .i_wdata (char_wdata),
        .i_re    (chb_re),
        .i_raddr (chb_raddr),
        .o_rdata (chb_rdata)
    );

    swti_ram #(.WIDTH(2 * LEN_W), .DEPTH(TABLE_DEPTH)) u_lens (
        .i_clk   (i_clk),
        .i_we    (len_we),
        .i_waddr (len_waddr),
        .i_wdata (len_wdata),
        .i_re    (len_re),
        .i_raddr (len_raddr),
        .o_rdata (len_rdata)
    );

    // back holds the sorted order table and drives the output register
    swti_back #(.TABLE_DEPTH(TABLE_DEPTH), .MAX_CHARS(MAX_CHARS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .i_cmd       (q_cmd),
        .o_cmd_pop   (pop),
        .o_len_re    (len_re),
        .o_len_raddr (len_raddr),
        .i_len_rdata (len_rdata),
        .o_cha_re    (cha_re),
        .o_cha_raddr (cha_raddr),
        .i_cha_rdata (cha_rdata),
        .o_chb_re    (chb_re),
        .o_chb_raddr (chb_raddr),
        .i_chb_rdata (chb_rdata),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

/* hw/rtl/swti_ram.sv */
// ----------------------------------------------------------------------------
// swti_ram
// simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module swti_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/swti_front.sv */
// ----------------------------------------------------------------------------
// swti_front
// takes input transfers, stores word characters, issues commands to the back
// ----------------------------------------------------------------------------
module swti_front
    import swti_pkg::*;
#(
    parameter int TABLE_DEPTH = 256,
    parameter int MAX_CHARS   = 48,
    localparam int OAW = $clog2(TABLE_DEPTH),
    localparam int CW  = $clog2(TABLE_DEPTH + 1),
    localparam int CAW = $clog2(TABLE_DEPTH * MAX_CHARS)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in                  i_in_data,
    input  logic                 i_q_ready,
    output logic                 o_cmd_valid,
    output t_cmd                 o_cmd,
    output logic                 o_char_we,
    output logic [CAW-1:0]       o_char_waddr,
    output logic [7:0]           o_char_wdata,
    output logic                 o_len_we,
    output logic [OAW-1:0]       o_len_waddr,
    output logic [2*LEN_W-1:0]   o_len_wdata
);

    localparam int XW = (CW > 8) ? CW : 8;

    logic [CW-1:0]    r_count, n_count;
    logic [CAW-1:0]   r_base, n_base;
    logic [LEN_W-1:0] r_plen, n_plen;
    logic [LEN_W-1:0] r_klen, n_klen;
    logic             r_live, n_live;

    logic             acc;
    logic             store;
    logic             full;
    logic [LEN_W-1:0] plen_w;
    logic [LEN_W-1:0] klen_w;
    logic             live_w;

    assign o_in_ready = i_q_ready;
    assign acc        = i_in_valid && i_q_ready;
    assign full       = (r_count == CW'(TABLE_DEPTH));
    assign store      = (i_in_data.char_code != 8'd0) && (r_plen < LEN_W'(MAX_CHARS));

    always_comb begin
        plen_w = r_plen;
        klen_w = r_klen;
        live_w = r_live;
        if (store) begin
            plen_w = r_plen + LEN_W'(1);
            if (r_live && f_is_lower(i_in_data.char_code)) begin
                klen_w = r_klen + LEN_W'(1);
            end else begin
                live_w = 1'b0;
            end
        end
    end

    always_comb begin
        n_count      = r_count;
        n_base       = r_base;
        n_plen       = r_plen;
        n_klen       = r_klen;
        n_live       = r_live;
        o_cmd_valid  = 1'b0;
        o_cmd.kind   = K_EMPTY;
        o_cmd.key_len    = klen_w;
        o_cmd.read_index = i_in_data.read_index;
        o_char_we    = 1'b0;
        o_char_waddr = r_base + CAW'(r_plen);
        o_char_wdata = i_in_data.char_code;
        o_len_we     = 1'b0;
        o_len_waddr  = OAW'(r_count);
        o_len_wdata  = {klen_w, plen_w};
        if (acc) begin
            if (i_in_data.mode) begin
                o_cmd_valid = 1'b1;
                if (XW'(i_in_data.read_index) >= XW'(r_count)) begin
                    o_cmd.kind = K_BADIDX;
                end else begin
                    o_cmd.kind = K_READ;
                end
            end else begin
                o_char_we = store && !full;
                n_plen    = plen_w;
                n_klen    = klen_w;
                n_live    = live_w;
                if (i_in_data.word_end) begin
                    o_cmd_valid = 1'b1;
                    n_plen = '0;
                    n_klen = '0;
                    n_live = 1'b1;
                    if (plen_w == '0) begin
                        o_cmd.kind = K_EMPTY;
                    end else if (full) begin
                        o_cmd.kind = K_FULL;
                    end else begin
                        o_cmd.kind = K_INS;
                        o_len_we   = 1'b1;
                        n_count    = r_count + CW'(1);
                        n_base     = r_base + CAW'(MAX_CHARS);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_base  <= '0;
            r_plen  <= '0;
            r_klen  <= '0;
            r_live  <= 1'b1;
        end else begin
            r_count <= n_count;
            r_base  <= n_base;
            r_plen  <= n_plen;
            r_klen  <= n_klen;
            r_live  <= n_live;
        end
    end

endmodule

/* hw/rtl/swti_queue.sv */
// ----------------------------------------------------------------------------
// swti_queue
// two entry command queue between front and back
// ----------------------------------------------------------------------------
module swti_queue
    import swti_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_ready,
    output logic o_valid,
    output t_cmd o_cmd,
    input  logic i_pop
);

    t_cmd       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       do_push, do_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_q[r_rp];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_q[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) begin
                r_wp <= !r_wp;
            end
            if (do_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(do_push) - 2'(do_pop);
        end
    end

endmodule

/* hw/rtl/swti_back.sv */
// ----------------------------------------------------------------------------
// swti_back
// binary search, order table shift and word read out
// ----------------------------------------------------------------------------
module swti_back
    import swti_pkg::*;
#(
    parameter int TABLE_DEPTH = 256,
    parameter int MAX_CHARS   = 48,
    localparam int OAW = $clog2(TABLE_DEPTH),
    localparam int CW  = $clog2(TABLE_DEPTH + 1),
    localparam int CAW = $clog2(TABLE_DEPTH * MAX_CHARS)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cmd_valid,
    input  t_cmd               i_cmd,
    output logic               o_cmd_pop,
    output logic               o_len_re,
    output logic [OAW-1:0]     o_len_raddr,
    input  logic [2*LEN_W-1:0] i_len_rdata,
    output logic               o_cha_re,
    output logic [CAW-1:0]     o_cha_raddr,
    input  logic [7:0]         i_cha_rdata,
    output logic               o_chb_re,
    output logic [CAW-1:0]     o_chb_raddr,
    input  logic [7:0]         i_chb_rdata,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output t_out               o_out_data
);

    typedef enum logic [13:0] {
        S_IDLE  = 14'b00000000000001,
        S_PROBE = 14'b00000000000010,
        S_SLOT  = 14'b00000000000100,
        S_KEY   = 14'b00000000001000,
        S_CHR   = 14'b00000000010000,
        S_CHK   = 14'b00000000100000,
        S_SHR   = 14'b00000001000000,
        S_SHW   = 14'b00000010000000,
        R_ORD   = 14'b00000100000000,
        R_SLOT  = 14'b00001000000000,
        R_LEN   = 14'b00010000000000,
        R_CHR   = 14'b00100000000000,
        R_CHK   = 14'b01000000000000,
        S_EMIT  = 14'b10000000000000
    } t_state;

    t_state           r_st, n_st;
    logic [CW-1:0]    r_count, n_count;
    logic [CW-1:0]    r_lo, n_lo, r_hi, n_hi, r_sh, n_sh;
    logic [OAW-1:0]   r_mid, n_mid, r_slot, n_slot;
    logic [CAW-1:0]   r_bnew, n_bnew, r_bold, n_bold;
    logic [LEN_W-1:0] r_ic, n_ic, r_m, n_m, r_kx, n_kx, r_ky, n_ky, r_len, n_len;
    logic [7:0]       r_ridx, n_ridx, r_held, n_held;
    logic             r_have, n_have;
    t_out             r_res, n_res;
    logic             r_ov, n_ov;
    t_out             r_out, n_out;

    logic             ord_we, ord_re;
    logic [OAW-1:0]   ord_waddr, ord_raddr, ord_wdata, ord_rdata;
    logic             out_free;
    logic             less;
    logic             decide;
    logic [CW-1:0]    mid_w;
    logic [LEN_W-1:0] ky_w;

    swti_ram #(.WIDTH(OAW), .DEPTH(TABLE_DEPTH)) u_order (
        .i_clk   (i_clk),
        .i_we    (ord_we),
        .i_waddr (ord_waddr),
        .i_wdata (ord_wdata),
        .i_re    (ord_re),
        .i_raddr (ord_raddr),
        .o_rdata (ord_rdata)
    );

    assign out_free    = !r_ov || i_out_ready;
    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;
    assign mid_w       = r_lo + ((r_hi - r_lo) >> 1);
    assign ky_w        = i_len_rdata[2*LEN_W-1:LEN_W];

    always_comb begin
        n_st    = r_st;
        n_count = r_count;
        n_lo    = r_lo;
        n_hi    = r_hi;
        n_sh    = r_sh;
        n_mid   = r_mid;
        n_slot  = r_slot;
        n_bnew  = r_bnew;
        n_bold  = r_bold;
        n_ic    = r_ic;
        n_m     = r_m;
        n_kx    = r_kx;
        n_ky    = r_ky;
        n_len   = r_len;
        n_ridx  = r_ridx;
        n_held  = r_held;
        n_have  = r_have;
        n_res   = r_res;
        n_ov    = r_ov && !i_out_ready;
        n_out   = r_out;
        o_cmd_pop   = 1'b0;
        o_len_re    = 1'b0;
        o_len_raddr = ord_rdata;
        o_cha_re    = 1'b0;
        o_cha_raddr = r_bnew + CAW'(r_ic);
        o_chb_re    = 1'b0;
        o_chb_raddr = r_bold + CAW'(r_ic);
        ord_we    = 1'b0;
        ord_waddr = OAW'(r_sh);
        ord_wdata = ord_rdata;
        ord_re    = 1'b0;
        ord_raddr = OAW'(mid_w);
        less      = 1'b0;
        decide    = 1'b0;
        case (r_st)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    n_res = '{letter_out: 8'd0, last_of_run: 1'b1,
                              insert_position: 8'd0, status: ST_OK};
                    case (i_cmd.kind)
                        K_INS: begin
                            n_kx = i_cmd.key_len;
                            n_lo = '0;
                            n_hi = r_count;
                            n_st = S_PROBE;
                        end
                        K_READ: begin
                            n_ridx = i_cmd.read_index;
                            n_st   = R_ORD;
                        end
                        K_FULL: begin
                            n_res.status = ST_FULL;
                            n_st = S_EMIT;
                        end
                        K_BADIDX: begin
                            n_res.status = ST_BADIDX;
                            n_st = S_EMIT;
                        end
                        default: begin
                            n_res.status = ST_EMPTY;
                            n_st = S_EMIT;
                        end
                    endcase
                end
            end
            S_PROBE: begin
                if (r_lo < r_hi) begin
                    ord_re = 1'b1;
                    n_mid  = OAW'(mid_w);
                    n_st   = S_SLOT;
                end else begin
                    n_sh = r_count;
                    n_st = S_SHR;
                end
            end
            S_SLOT: begin
                n_slot   = ord_rdata;
                o_len_re = 1'b1;
                n_st     = S_KEY;
            end
            S_KEY: begin
                n_ky   = ky_w;
                n_m    = (ky_w < r_kx) ? ky_w : r_kx;
                n_bold = CAW'(r_slot) * CAW'(MAX_CHARS);
                n_ic   = '0;
                n_st   = S_CHR;
            end
            S_CHR: begin
                if (r_ic < r_m) begin
                    o_cha_re = 1'b1;
                    o_chb_re = 1'b1;
                    n_st     = S_CHK;
                end else begin
                    less   = (r_ky > r_kx);
                    decide = 1'b1;
                end
            end
            S_CHK: begin
                if (i_cha_rdata != i_chb_rdata) begin
                    less   = (i_cha_rdata < i_chb_rdata);
                    decide = 1'b1;
                end else begin
                    n_ic = r_ic + LEN_W'(1);
                    n_st = S_CHR;
                end
            end
            S_SHR: begin
                if (r_sh > r_lo) begin
                    ord_re    = 1'b1;
                    ord_raddr = OAW'(r_sh - CW'(1));
                    n_st      = S_SHW;
                end else begin
                    ord_we    = 1'b1;
                    ord_waddr = OAW'(r_lo);
                    ord_wdata = OAW'(r_count);
                    n_res.insert_position = r_lo[7:0];
                    n_count = r_count + CW'(1);
                    n_bnew  = r_bnew + CAW'(MAX_CHARS);
                    n_st    = S_EMIT;
                end
            end
            S_SHW: begin
                ord_we = 1'b1;
                n_sh   = r_sh - CW'(1);
                n_st   = S_SHR;
            end
            R_ORD: begin
                ord_re    = 1'b1;
                ord_raddr = OAW'(r_ridx);
                n_st      = R_SLOT;
            end
            R_SLOT: begin
                n_slot   = ord_rdata;
                o_len_re = 1'b1;
                n_st     = R_LEN;
            end
            R_LEN: begin
                n_len  = i_len_rdata[LEN_W-1:0];
                n_bold = CAW'(r_slot) * CAW'(MAX_CHARS);
                n_ic   = '0;
                n_have = 1'b0;
                n_st   = R_CHR;
            end
            R_CHR: begin
                o_cha_raddr = r_bold + CAW'(r_ic);
                if (r_ic < r_len) begin
                    o_cha_re = 1'b1;
                    n_st     = R_CHK;
                end else begin
                    if (r_have) begin
                        n_res.letter_out = r_held;
                    end else begin
                        n_res.status = ST_EMPTY;
                    end
                    n_st = S_EMIT;
                end
            end
            R_CHK: begin
                if (!f_is_letter(i_cha_rdata)) begin
                    n_ic = r_ic + LEN_W'(1);
                    n_st = R_CHR;
                end else if (!r_have) begin
                    n_held = i_cha_rdata;
                    n_have = 1'b1;
                    n_ic   = r_ic + LEN_W'(1);
                    n_st   = R_CHR;
                end else if (out_free) begin
                    // previous letter is not the last one
                    n_ov   = 1'b1;
                    n_out  = '{letter_out: r_held, last_of_run: 1'b0,
                              insert_position: 8'd0, status: ST_OK};
                    n_held = i_cha_rdata;
                    n_ic   = r_ic + LEN_W'(1);
                    n_st   = R_CHR;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_ov  = 1'b1;
                    n_out = r_res;
                    n_st  = S_IDLE;
                end
            end
            default: begin
                n_st = S_IDLE;
            end
        endcase
        if (decide) begin
            if (less) begin
                n_hi = CW'(r_mid);
            end else begin
                n_lo = CW'(r_mid) + CW'(1);
            end
            n_st = S_PROBE;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo   <= n_lo;
        r_hi   <= n_hi;
        r_sh   <= n_sh;
        r_mid  <= n_mid;
        r_slot <= n_slot;
        r_bold <= n_bold;
        r_ic   <= n_ic;
        r_m    <= n_m;
        r_kx   <= n_kx;
        r_ky   <= n_ky;
        r_len  <= n_len;
        r_ridx <= n_ridx;
        r_held <= n_held;
        r_have <= n_have;
        r_res  <= n_res;
        r_out  <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= S_IDLE;
            r_count <= '0;
            r_bnew  <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_st    <= n_st;
            r_count <= n_count;
            r_bnew  <= n_bnew;
            r_ov    <= n_ov;
        end
    end

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TABLE_DEPTH))
        else $error("word count beyond table depth");

    a_search_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_PROBE) |-> (r_lo <= r_hi) && (r_hi <= r_count))
        else $error("search bounds out of order");

    a_shift_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_SHW) |-> (r_sh > r_lo) && (r_sh <= r_count))
        else $error("shift pointer out of range");

    a_insert_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_SHR) && (r_sh <= r_lo) |=> (r_count == $past(r_count) + CW'(1)))
        else $error("placed word not counted");
`endif

endmodule

/* tb/sv/sorted_word_table_insert_checker.sv */
// ----------------------------------------------------------------------------
// sorted_word_table_insert_checker
// watches both channels, keeps its own sorted word table, predicts each
// result and compares it field by field with what the block emits
// ----------------------------------------------------------------------------
module sorted_word_table_insert_checker
    import swti_pkg::*;
#(
    parameter int TABLE_DEPTH = 256,
    parameter int MAX_CHARS   = 48
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_in_ready,
    input  t_in  i_in_data,
    input  logic i_out_valid,
    input  logic i_out_ready,
    input  t_out i_out_data,
    output int   o_fail_count,
    output int   o_pending_count,
    output int   o_word_count,
    output int   o_result_count
);

    typedef logic [7:0] t_word [MAX_CHARS];

    t_word      table_words [TABLE_DEPTH];
    int         table_lens  [TABLE_DEPTH];
    int         stored;
    t_word      collect_chars;
    int         collect_len;
    t_out       expected_results [$];

    assign o_pending_count = expected_results.size();
    assign o_word_count    = stored;

    function automatic int lower_run(t_word w, int len);
        int k;
        k = 0;
        while (k < len && w[k] >= CH_LOW_A && w[k] <= CH_LOW_Z) k++;
        return k;
    endfunction

    // strict order of the lowercase prefixes, shorter prefix first on a tie
    function automatic bit sorts_before(t_word x, int xl, t_word y, int yl);
        int kx, ky, m;
        kx = lower_run(x, xl);
        ky = lower_run(y, yl);
        m  = kx < ky ? kx : ky;
        for (int i = 0; i < m; i++) begin
            if (x[i] < y[i]) return 1'b1;
            if (x[i] > y[i]) return 1'b0;
        end
        return ky > kx;
    endfunction

    function automatic t_out mk(logic [7:0] l, logic last, logic [7:0] p, logic [1:0] s);
        t_out r;
        r.letter_out = l;
        r.last_of_run = last;
        r.insert_position = p;
        r.status = s;
        return r;
    endfunction

    function automatic bit f_letter(logic [7:0] c);
        return (c >= CH_LOW_A && c <= CH_LOW_Z) || (c >= CH_UP_A && c <= CH_UP_Z);
    endfunction

    task automatic predict_transfer(t_in d);
        int lo, hi, mid, n;
        if (!d.mode) begin
            if (d.char_code != 8'd0 && collect_len < MAX_CHARS) begin
                collect_chars[collect_len] = d.char_code;
                collect_len++;
            end
            if (!d.word_end) return;
            if (collect_len == 0) begin
                expected_results.push_back(mk(8'd0, 1'b1, 8'd0, ST_EMPTY));
            end else if (stored >= TABLE_DEPTH) begin
                collect_len = 0;
                expected_results.push_back(mk(8'd0, 1'b1, 8'd0, ST_FULL));
            end else begin
                lo = 0;
                hi = stored;
                while (lo < hi) begin
                    mid = lo + (hi - lo) / 2;
                    if (sorts_before(collect_chars, collect_len, table_words[mid],
                                     table_lens[mid]))
                        hi = mid;
                    else
                        lo = mid + 1;
                end
                for (int i = stored; i > lo; i--) begin
                    table_words[i] = table_words[i-1];
                    table_lens[i]  = table_lens[i-1];
                end
                table_words[lo] = collect_chars;
                table_lens[lo]  = collect_len;
                stored++;
                collect_len = 0;
                expected_results.push_back(mk(8'd0, 1'b1, lo[7:0], ST_OK));
            end
        end else begin
            if (d.read_index >= stored) begin
                expected_results.push_back(mk(8'd0, 1'b1, 8'd0, ST_BADIDX));
                return;
            end
            n = 0;
            for (int i = 0; i < table_lens[d.read_index]; i++) begin
                if (f_letter(table_words[d.read_index][i])) begin
                    expected_results.push_back(mk(table_words[d.read_index][i], 1'b0,
                                                  8'd0, ST_OK));
                    n++;
                end
            end
            if (n == 0)
                expected_results.push_back(mk(8'd0, 1'b1, 8'd0, ST_EMPTY));
            else
                expected_results[$].last_of_run = 1'b1;
        end
    endtask

    always @(posedge i_clk) begin
        t_out exp_r;
        if (!i_rst_n) begin
            stored       = 0;
            collect_len  = 0;
            o_fail_count <= 0;
            o_result_count <= 0;
            expected_results.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                o_result_count <= o_result_count + 1;
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result %p", $time, i_out_data);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (exp_r !== i_out_data) begin
                        $display("%0t: mismatch expected %p actual %p", $time, exp_r,
                                 i_out_data);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                predict_transfer(i_in_data);
            end
        end
    end

endmodule

/* tb/sv/sorted_word_table_insert_tb.sv */
// ----------------------------------------------------------------------------
// sorted_word_table_insert_tb
// drives words and read-outs into the sorted word table with bursty input and
// stalled output; a checker beside the block predicts and compares results
// ----------------------------------------------------------------------------
module sorted_word_table_insert_tb;
    import swti_pkg::*;

    localparam int TABLE_DEPTH = 256;
    localparam int MAX_CHARS   = 48;

    logic i_clk;
    logic i_rst_n;
    logic in_valid;
    logic in_ready;
    t_in  in_data;
    logic out_valid;
    logic out_ready;
    t_out out_data;
    int   fail_count;
    int   pending_count;
    int   word_count;
    int   result_count;

    // sender burst shaping
    int burst_left;
    int sent_items;
    int inserted_words;

    sorted_word_table_insert #(
        .TABLE_DEPTH(TABLE_DEPTH),
        .MAX_CHARS  (MAX_CHARS)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_data (out_data)
    );

    sorted_word_table_insert_checker #(
        .TABLE_DEPTH(TABLE_DEPTH),
        .MAX_CHARS  (MAX_CHARS)
    ) u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (in_valid),
        .i_in_ready     (in_ready),
        .i_in_data      (in_data),
        .i_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .i_out_data     (out_data),
        .o_fail_count   (fail_count),
        .o_pending_count(pending_count),
        .o_word_count   (word_count),
        .o_result_count (result_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // receiver stall pattern: long ready stretches, random stalls, some long holds
    initial begin
        int phase;
        out_ready = 1'b0;
        phase = 0;
        forever begin
            @(posedge i_clk);
            phase++;
            if ((phase / 64) % 4 == 3)
                out_ready <= 1'b1;
            else if ((phase / 64) % 4 == 1)
                out_ready <= ($urandom_range(0, 9) == 0);
            else
                out_ready <= ($urandom_range(0, 3) != 0);
        end
    end

    // one transfer: hold valid and payload until accepted, with burst gaps
    task automatic send_item(t_in d);
        if (burst_left == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            burst_left = $urandom_range(1, 12);
        end
        in_valid <= 1'b1;
        in_data  <= d;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        burst_left--;
        sent_items++;
    endtask

    task automatic send_char(logic [7:0] c, logic wend);
        t_in d;
        d.mode       = 1'b0;
        d.char_code  = c;
        d.word_end   = wend;
        d.read_index = 8'($urandom);
        send_item(d);
    endtask

    task automatic send_read(logic [7:0] idx);
        t_in d;
        d.mode       = 1'b1;
        d.char_code  = 8'($urandom);
        d.word_end   = 1'($urandom);
        d.read_index = idx;
        send_item(d);
    endtask

    function automatic logic [7:0] rand_char();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) return 8'($urandom_range(CH_LOW_A, CH_LOW_A + 3));
        if (r < 8) return 8'($urandom_range(CH_LOW_A, CH_LOW_Z));
        if (r < 9) return 8'($urandom_range(CH_UP_A, CH_UP_Z));
        return 8'($urandom);
    endfunction

    // a random word, mostly short so many keys collide on prefixes
    task automatic send_word(int len);
        for (int i = 0; i < len - 1; i++) send_char(rand_char(), 1'b0);
        send_char(rand_char(), 1'b1);
        inserted_words++;
    endtask

    initial begin
        int total;
        in_valid   = 1'b0;
        in_data    = '0;
        i_rst_n    = 1'b0;
        burst_left = 0;
        sent_items = 0;
        inserted_words = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty table read, empty word, zero-byte end, basic order
        send_read(8'd0);
        send_char(8'd0, 1'b1);
        send_char(8'd0, 1'b0);
        send_char(8'd0, 1'b1);
        send_char("b", 1'b0);
        send_char("a", 1'b1);
        send_char("a", 1'b1);
        send_char("b", 1'b0);
        send_char("a", 1'b0);
        send_char(8'd0, 1'b1);
        // no-letter word with an extreme byte, then mixed case
        send_char(8'hff, 1'b0);
        send_char("9", 1'b1);
        send_char("Z", 1'b0);
        send_char("z", 1'b1);
        send_read(8'd0);
        send_read(8'd2);
        send_read(8'd3);
        send_read(8'hff);
        // overlong word, truncated past the last slot
        for (int i = 0; i < MAX_CHARS + 3; i++)
            send_char(i % 2 ? "A" : "y", i == MAX_CHARS + 2);
        send_read(8'd5);

        // random: mostly well formed words, reads of stored entries, some noise
        total = 0;
        while (total < 30) begin
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    send_read(word_count > 0 && $urandom_range(0, 5) != 0
                              ? 8'($urandom_range(0, word_count - 1)) : 8'($urandom));
                    total++;
                end
                3: begin
                    send_char(8'($urandom), 1'($urandom));
                    total++;
                end
                default: begin
                    int len;
                    len = ($urandom_range(0, 19) == 0) ? $urandom_range(MAX_CHARS - 2, 60)
                                                       : $urandom_range(1, 6);
                    send_word(len);
                    total += len;
                end
            endcase
        end
        // fill the table to hit the full case, then read across it
        while (word_count < TABLE_DEPTH) begin
            send_word(1);
            while (pending_count > 40) @(posedge i_clk);
        end
        send_word(2);
        send_char(8'd0, 1'b1);
        send_read(8'd0);
        send_read(8'($urandom));
        send_read(8'hff);
        in_valid <= 1'b0;

        while (pending_count != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        $display("covered %0d transfers in, %0d words sent, %0d results", sent_items,
                 inserted_words, result_count);
        $display("table filled to %0d words, full and invalid index cases hit", word_count);
        if (fail_count == 0 && pending_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // watchdog: far beyond the slowest legal run
    initial begin
        #400000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
